[sv/assert_macros.svh]
// Assertion macros shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[sv/msm_pkg.sv]
// Package with widths, types and constants of the timestamp matcher.
package msm_pkg;
   localparam int FifoDepth = 64;
   localparam int AddrW = $clog2(FifoDepth);
   localparam int CountW = AddrW + 1;
   localparam int StampW = 63;
   localparam int TagW = 16;
   localparam int DiffW = 32;
   localparam int EntryW = StampW + TagW;

   typedef enum logic [1:0] {
      OP_MASTER = 2'd0,
      OP_LEFT = 2'd1,
      OP_RIGHT = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic {
      REG_MAX_DIFF = 1'b0,
      REG_FIFO_LIMIT = 1'b1
   } reg_type;

   localparam logic [31:0] MaxDiffReset = 32'd300000000;
   localparam logic [6:0] FifoLimitReset = 7'd50;
   localparam logic [DiffW-1:0] DiffSat = '1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PUSH = 6'b000010,
      ST_MREAD = 6'b000100,
      ST_MWAIT = 6'b001000,
      ST_SCAN = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   // Scan control shared by the two slave lanes.
   typedef struct packed {
      logic start;
      logic sample;
      logic [CountW-1:0] index;
   } scan_ctl_type;
endpackage

[sv/msm_if.sv]
// Valid/ready channel interfaces for items, results and configuration writes.
interface msm_req_if;
   logic valid;
   logic ready;
   logic [1:0] operation;
   logic [msm_pkg::StampW-1:0] frame_stamp;
   logic [msm_pkg::TagW-1:0] frame_tag;
   modport source (output valid, operation, frame_stamp, frame_tag, input ready);
   modport sink (input valid, operation, frame_stamp, frame_tag, output ready);
endinterface

interface msm_rsp_if;
   logic valid;
   logic ready;
   logic [msm_pkg::TagW-1:0] master_tag;
   logic [msm_pkg::StampW-1:0] master_stamp;
   logic left_hit;
   logic [msm_pkg::TagW-1:0] left_tag;
   logic [msm_pkg::DiffW-1:0] left_diff_ns;
   logic right_hit;
   logic [msm_pkg::TagW-1:0] right_tag;
   logic [msm_pkg::DiffW-1:0] right_diff_ns;
   logic both_hit;
   modport source (output valid, master_tag, master_stamp, left_hit, left_tag,
      left_diff_ns, right_hit, right_tag, right_diff_ns, both_hit, input ready);
   modport sink (input valid, master_tag, master_stamp, left_hit, left_tag,
      left_diff_ns, right_hit, right_tag, right_diff_ns, both_hit, output ready);
endinterface

interface msm_csr_if;
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/master_slave_timestamp_matcher_core.sv]
// Top level of the master/slave nearest-timestamp frame matcher.
// The block takes one item at a time. A slave push passes through ST_PUSH.
// A master push runs ST_PUSH, ST_MREAD, ST_MWAIT, ST_SCAN and ST_DONE, and a
// sync tick the same states without ST_PUSH. ST_SCAN makes one RAM read per
// entry of the larger slave fill (up to 64), both slaves scanned in parallel
// by a shared index counter. A sync with an empty master FIFO ends at ST_MREAD.
// A result waits in its register while the block takes further items; a
// sync that finishes while the previous result waits stalls until it is taken.
`include "assert_macros.svh"
module master_slave_timestamp_matcher_core (
   input logic clock,
   input logic reset,
   msm_req_if.sink req,
   msm_rsp_if.source rsp,
   msm_csr_if.sink csr
);
   msm_pkg::state_type state_ff, state_in;
   logic [31:0] max_diff_ff;
   logic [6:0] limit_ff;
   logic [msm_pkg::CountW-1:0] limit_eff;
   logic [1:0] op_ff;
   logic [msm_pkg::StampW-1:0] stamp_ff;
   logic [msm_pkg::TagW-1:0] tag_ff;
   logic [msm_pkg::CountW-1:0] idx_ff, idx_in;
   logic [msm_pkg::CountW-1:0] scan_n;
   logic smp_ff, smp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [msm_pkg::AddrW-1:0] m_head_ff, m_head_in;
   logic [msm_pkg::CountW-1:0] m_count_ff, m_count_in;
   logic [msm_pkg::EntryW-1:0] m_rdata;
   logic [msm_pkg::StampW-1:0] ref_ff;
   logic [msm_pkg::TagW-1:0] ref_tag_ff;
   logic m_push, l_push, r_push, commit, accept;
   logic [msm_pkg::CountW:0] m_grown;
   msm_pkg::scan_ctl_type ctl;
   logic [msm_pkg::CountW-1:0] l_count, r_count;
   logic l_m, r_m;
   logic [msm_pkg::TagW-1:0] l_tag, r_tag;
   logic [msm_pkg::DiffW-1:0] l_diff, r_diff;

   assign limit_eff = (limit_ff > 7'(msm_pkg::FifoDepth)) ?
      msm_pkg::CountW'(msm_pkg::FifoDepth) : msm_pkg::CountW'(limit_ff);
   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == msm_pkg::ST_IDLE);
   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_diff_ff <= msm_pkg::MaxDiffReset;
         limit_ff <= msm_pkg::FifoLimitReset;
      end else if (csr.valid) begin
         case (msm_pkg::reg_type'(csr.index))
            msm_pkg::REG_MAX_DIFF: max_diff_ff <= csr.data;
            msm_pkg::REG_FIFO_LIMIT: limit_ff <= csr.data[6:0];
            default: limit_ff <= limit_ff;
         endcase
      end
   end

   assign m_push = (state_ff == msm_pkg::ST_PUSH) && (op_ff == msm_pkg::OP_MASTER);
   assign l_push = (state_ff == msm_pkg::ST_PUSH) && (op_ff == msm_pkg::OP_LEFT);
   assign r_push = (state_ff == msm_pkg::ST_PUSH) && (op_ff == msm_pkg::OP_RIGHT);
   assign commit = (state_ff == msm_pkg::ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign scan_n = (l_count > r_count) ? l_count : r_count;
   assign ctl.start = (state_ff == msm_pkg::ST_MWAIT);
   assign ctl.sample = smp_ff;
   assign ctl.index = idx_ff - 1'b1;

   msm_ram #(.Width(msm_pkg::EntryW), .Depth(msm_pkg::FifoDepth)) u_mram (
      .clock(clock), .we(m_push),
      .waddr(m_head_ff + m_count_ff[msm_pkg::AddrW-1:0]),
      .wdata({stamp_ff, tag_ff}), .raddr(m_head_ff), .rdata(m_rdata)
   );

   msm_slave u_left (
      .clock(clock), .reset(reset), .push(l_push), .push_stamp(stamp_ff),
      .push_tag(tag_ff), .limit(limit_eff), .ctl(ctl), .ref_stamp(ref_ff),
      .max_diff(max_diff_ff), .commit(commit), .count(l_count), .matched(l_m),
      .tag(l_tag), .diff(l_diff)
   );

   msm_slave u_right (
      .clock(clock), .reset(reset), .push(r_push), .push_stamp(stamp_ff),
      .push_tag(tag_ff), .limit(limit_eff), .ctl(ctl), .ref_stamp(ref_ff),
      .max_diff(max_diff_ff), .commit(commit), .count(r_count), .matched(r_m),
      .tag(r_tag), .diff(r_diff)
   );

   assign m_grown = {1'b0, m_count_ff} + 1'b1;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      smp_in = 1'b0;
      m_head_in = m_head_ff;
      m_count_in = m_count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (m_push) begin
         if (m_grown > {1'b0, limit_eff}) begin
            m_count_in = limit_eff;
            m_head_in = m_head_ff + m_grown[msm_pkg::AddrW-1:0]
               - limit_eff[msm_pkg::AddrW-1:0];
         end else begin
            m_count_in = m_grown[msm_pkg::CountW-1:0];
         end
      end
      case (state_ff)
         msm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req.operation == msm_pkg::OP_TICK) ?
                  msm_pkg::ST_MREAD : msm_pkg::ST_PUSH;
            end
         end
         msm_pkg::ST_PUSH: begin
            state_in = (op_ff == msm_pkg::OP_MASTER) ? msm_pkg::ST_MREAD
               : msm_pkg::ST_IDLE;
         end
         msm_pkg::ST_MREAD: begin
            state_in = (m_count_ff == '0) ? msm_pkg::ST_IDLE : msm_pkg::ST_MWAIT;
         end
         msm_pkg::ST_MWAIT: begin
            idx_in = '0;
            state_in = msm_pkg::ST_SCAN;
         end
         msm_pkg::ST_SCAN: begin
            // Index runs one ahead of the sample because of the RAM read latency.
            if (idx_ff == scan_n) begin
               state_in = msm_pkg::ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
               smp_in = 1'b1;
            end
         end
         msm_pkg::ST_DONE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               m_head_in = m_head_ff + 1'b1;
               m_count_in = m_count_ff - 1'b1;
               state_in = msm_pkg::ST_IDLE;
            end
         end
         default: state_in = msm_pkg::ST_IDLE;
      endcase
   end

   // The slave scan reads entry idx, sampled the next cycle as index idx.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         m_head_ff <= '0;
         m_count_ff <= '0;
         smp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         m_head_ff <= m_head_in;
         m_count_ff <= m_count_in;
         smp_ff <= smp_in;
      end
      idx_ff <= idx_in;
      if (accept) begin
         op_ff <= req.operation;
         stamp_ff <= req.frame_stamp;
         tag_ff <= req.frame_tag;
      end
      if (state_ff == msm_pkg::ST_MWAIT) begin
         ref_ff <= m_rdata[msm_pkg::EntryW-1:msm_pkg::TagW];
         ref_tag_ff <= m_rdata[msm_pkg::TagW-1:0];
      end
      if (commit) begin
         rsp.master_tag <= ref_tag_ff;
         rsp.master_stamp <= ref_ff;
         rsp.left_hit <= l_m;
         rsp.left_tag <= l_tag;
         rsp.left_diff_ns <= l_diff;
         rsp.right_hit <= r_m;
         rsp.right_tag <= r_tag;
         rsp.right_diff_ns <= r_diff;
         rsp.both_hit <= l_m && r_m;
      end
   end

   assign rsp.valid = rsp_valid_ff;

   `ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != msm_pkg::ST_IDLE, !req.ready, "busy block accepted item")
   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, m_count_ff <= msm_pkg::CountW'(msm_pkg::FifoDepth), "master count overflow")
   `ASSERT_NEXT(a_done_resp, clock, reset, commit, rsp.valid, "sync finished without result")
endmodule

[sv/msm_ram.sv]
// Generic single-port-write RAM with a registered read port.
module msm_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input logic clock,
   input logic we,
   input logic [$clog2(Depth)-1:0] waddr,
   input logic [Width-1:0] wdata,
   input logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0] rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/msm_slave.sv]
// One slave FIFO: storage, push with limit trim, and a nearest-entry scan.
module msm_slave (
   input logic clock,
   input logic reset,
   input logic push,
   input logic [msm_pkg::StampW-1:0] push_stamp,
   input logic [msm_pkg::TagW-1:0] push_tag,
   input logic [msm_pkg::CountW-1:0] limit,
   input msm_pkg::scan_ctl_type ctl,
   input logic [msm_pkg::StampW-1:0] ref_stamp,
   input logic [31:0] max_diff,
   input logic commit,
   output logic [msm_pkg::CountW-1:0] count,
   output logic matched,
   output logic [msm_pkg::TagW-1:0] tag,
   output logic [msm_pkg::DiffW-1:0] diff
);
   logic [msm_pkg::AddrW-1:0] head_ff, head_in;
   logic [msm_pkg::CountW-1:0] count_ff, count_in;
   logic found_ff, found_in;
   logic [msm_pkg::StampW-1:0] best_ff, best_in;
   logic [msm_pkg::CountW-1:0] best_i_ff, best_i_in;
   logic [msm_pkg::TagW-1:0] best_tag_ff, best_tag_in;
   logic [msm_pkg::EntryW-1:0] rdata;
   logic [msm_pkg::AddrW-1:0] waddr, raddr;
   logic [msm_pkg::StampW-1:0] st, d;
   logic [msm_pkg::CountW:0] grown;

   assign waddr = head_ff + count_ff[msm_pkg::AddrW-1:0];
   assign raddr = head_ff + ctl.index[msm_pkg::AddrW-1:0] + 1'b1;

   msm_ram #(.Width(msm_pkg::EntryW), .Depth(msm_pkg::FifoDepth)) u_ram (
      .clock(clock), .we(push), .waddr(waddr), .wdata({push_stamp, push_tag}),
      .raddr(raddr), .rdata(rdata)
   );

   assign st = rdata[msm_pkg::EntryW-1:msm_pkg::TagW];
   assign d = (st > ref_stamp) ? st - ref_stamp : ref_stamp - st;
   assign grown = {1'b0, count_ff} + 1'b1;

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_i_in = best_i_ff;
      best_tag_in = best_tag_ff;
      if (push) begin
         // A FIFO full to its depth writes over its oldest entry, which the trim then drops.
         if (grown > {1'b0, limit}) begin
            count_in = limit;
            head_in = head_ff + grown[msm_pkg::AddrW-1:0] - limit[msm_pkg::AddrW-1:0];
         end else begin
            count_in = grown[msm_pkg::CountW-1:0];
         end
      end
      if (ctl.start) begin
         found_in = 1'b0;
      end
      if (ctl.sample && (ctl.index < count_ff) && (!found_ff || d < best_ff)) begin
         found_in = 1'b1;
         best_in = d;
         best_i_in = ctl.index;
         best_tag_in = rdata[msm_pkg::TagW-1:0];
      end
      if (commit && matched) begin
         head_in = head_ff + best_i_ff[msm_pkg::AddrW-1:0] + 1'b1;
         count_in = count_ff - best_i_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         count_ff <= count_in;
         found_ff <= found_in;
      end
      best_ff <= best_in;
      best_i_ff <= best_i_in;
      best_tag_ff <= best_tag_in;
   end

   assign count = count_ff;
   assign matched = found_ff && (best_ff < {31'd0, max_diff});
   assign tag = found_ff ? best_tag_ff : '0;
   assign diff = !found_ff ? msm_pkg::DiffSat :
      (|best_ff[msm_pkg::StampW-1:msm_pkg::DiffW]) ? msm_pkg::DiffSat :
      best_ff[msm_pkg::DiffW-1:0];
endmodule
